[rtl/core/indexed_shift_list_defines.svh]
// assertion helpers for the checker file
`ifndef INDEXED_SHIFT_LIST_DEFINES_SVH
`define INDEXED_SHIFT_LIST_DEFINES_SVH

// same-cycle implication
`define ISL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/isl_pkg.sv]
package isl_pkg;

	// fixed port widths of the command and result words
	localparam int IDX_W = 5;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;

	typedef enum logic [2:0] {
		CMD_GET    = 3'd0,
		CMD_SET    = 3'd1,
		CMD_PUSH   = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_ERASE  = 3'd4,
		CMD_RESIZE = 3'd5
	} isl_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GET_WAIT,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_PUT
	} isl_state_t;

endpackage

[rtl/core/isl_ram.sv]
module isl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/indexed_shift_list.sv]
// Fixed-capacity ordered list of words with get, set, push, insert, erase and resize.
// A command is taken when start is high and busy is low; busy stays high while it
// runs, and the result (ok, read_value, count) is shown for one cycle with done high.
// The receiver cannot stall, so capture the result on the done cycle. Entries live in
// a single-port-write, registered-read RAM and one pointer step unit walks it. Set, push,
// resize, refused commands and an erase of the last entry finish in EXEC; get reads in
// EXEC and returns from GET_WAIT; insert and erase move each shifted entry through a
// MOVE_RD/MOVE_WR pair, and insert then writes its value in PUT (in EXEC when index
// equals count). done rises as busy falls. Unwritten entries read back undefined.
module indexed_shift_list import isl_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       cmd,
	input  logic [IDX_W-1:0] index,
	input  logic [VAL_W-1:0] value,
	input  logic [IDX_W-1:0] new_length,
	output logic             done,
	output logic             ok,
	output logic [VAL_W-1:0] read_value,
	output logic [CNT_W-1:0] count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > IDX_W) ? CW : IDX_W;
	localparam int XW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

	isl_state_t state_q, state_nxt;

	logic [2:0]       cmd_q;
	logic [IDX_W-1:0] index_q;
	logic [VAL_W-1:0] value_q;
	logic [IDX_W-1:0] new_length_q;
	logic [CW-1:0]    count_q, count_nxt;
	logic [AW-1:0]    ptr_q, ptr_nxt;
	logic             done_q, ok_q;
	logic [VAL_W-1:0] read_value_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	logic                  fin, fin_ok, rd_sel;
	logic [IW-1:0]         idx_x, cnt_x, len_x;
	logic [AW-1:0]         idx_a, cnt_a, src_a;
	logic [XW-1:0]         val_x, rd_x;
	logic [DATA_WIDTH-1:0] val_w;
	logic                  is_ins, in_rng, full, ins_ok, len_ok, erase_more0, erase_more;

	assign idx_x = IW'(index_q);
	assign cnt_x = IW'(count_q);
	assign len_x = IW'(new_length_q);
	assign idx_a = idx_x[AW-1:0];
	assign cnt_a = count_q[AW-1:0];
	assign val_x = XW'(value_q);
	assign val_w = val_x[DATA_WIDTH-1:0];
	assign rd_x  = XW'(ram_rdata);

	assign is_ins = (cmd_q == CMD_INSERT);
	assign in_rng = (idx_x < cnt_x);
	assign full   = (count_q == CAP_C);
	assign ins_ok = (idx_x <= cnt_x) && !full;
	assign len_ok = (len_x <= CAP_I);

	// shared pointer step: insert walks down, erase walks up
	assign src_a       = is_ins ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
	assign erase_more0 = ((idx_x + IW'(1)) < cnt_x);
	assign erase_more  = ((CW'(src_a) + CW'(1)) < count_q);

	isl_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
				case (cmd_q)
					CMD_GET: begin
						if (in_rng) begin
							state_nxt = ST_GET_WAIT;
						end
					end
					CMD_INSERT: begin
						if (ins_ok && (idx_x != cnt_x)) begin
							state_nxt = ST_MOVE_RD;
						end
					end
					CMD_ERASE: begin
						if (in_rng && erase_more0) begin
							state_nxt = ST_MOVE_RD;
						end
					end
					default: state_nxt = ST_IDLE;
				endcase
			end
			ST_GET_WAIT: state_nxt = ST_IDLE;
			ST_MOVE_RD:  state_nxt = ST_MOVE_WR;
			ST_MOVE_WR: begin
				if (is_ins) begin
					state_nxt = (src_a == idx_a) ? ST_PUT : ST_MOVE_RD;
				end else begin
					state_nxt = erase_more ? ST_MOVE_RD : ST_IDLE;
				end
			end
			ST_PUT:  state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_a;
		ram_wdata = val_w;
		ram_raddr = idx_a;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		rd_sel    = 1'b0;
		count_nxt = count_q;
		ptr_nxt   = ptr_q;
		unique case (state_q)
			ST_EXEC: begin
				case (cmd_q)
					CMD_GET: begin
						// in range: read issued here, result next cycle
						fin = !in_rng;
					end
					CMD_SET: begin
						fin    = 1'b1;
						fin_ok = in_rng;
						ram_we = in_rng;
					end
					CMD_PUSH: begin
						fin = 1'b1;
						if (!full) begin
							ram_we    = 1'b1;
							ram_waddr = cnt_a;
							fin_ok    = 1'b1;
							count_nxt = count_q + CW'(1);
						end
					end
					CMD_INSERT: begin
						if (!ins_ok) begin
							fin = 1'b1;
						end else if (idx_x == cnt_x) begin
							ram_we    = 1'b1;
							fin       = 1'b1;
							fin_ok    = 1'b1;
							count_nxt = count_q + CW'(1);
						end else begin
							ptr_nxt = cnt_a;
						end
					end
					CMD_ERASE: begin
						if (!in_rng) begin
							fin = 1'b1;
						end else if (!erase_more0) begin
							fin       = 1'b1;
							fin_ok    = 1'b1;
							count_nxt = count_q - CW'(1);
						end else begin
							ptr_nxt = idx_a;
						end
					end
					CMD_RESIZE: begin
						fin = 1'b1;
						if (len_ok) begin
							fin_ok    = 1'b1;
							count_nxt = len_x[CW-1:0];
						end
					end
					default: fin = 1'b1;
				endcase
			end
			ST_GET_WAIT: begin
				fin    = 1'b1;
				fin_ok = 1'b1;
				rd_sel = 1'b1;
			end
			ST_MOVE_RD: begin
				ram_raddr = src_a;
			end
			ST_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
				ptr_nxt   = src_a;
				if (!is_ins && !erase_more) begin
					fin       = 1'b1;
					fin_ok    = 1'b1;
					count_nxt = count_q - CW'(1);
				end
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				fin       = 1'b1;
				fin_ok    = 1'b1;
				count_nxt = count_q + CW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			cmd_q        <= cmd;
			index_q      <= index;
			value_q      <= value;
			new_length_q <= new_length;
		end
		ptr_q <= ptr_nxt;
		if (fin) begin
			ok_q         <= fin_ok;
			read_value_q <= rd_sel ? rd_x[VAL_W-1:0] : '0;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign ok         = ok_q;
	assign read_value = read_value_q;
	assign count      = cnt_x[CNT_W-1:0];

endmodule

[rtl/core/isl_checker.sv]
`include "indexed_shift_list_defines.svh"

module isl_checker import isl_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             ok,
	input logic [VAL_W-1:0] read_value,
	input logic [CNT_W-1:0] count
);

	logic take;

	assign take = start && !busy;

	`ISL_ASSERT_NXT(a_take_busy, clk, arst_n, take, busy, "accepted word did not raise busy")
	`ISL_ASSERT_NXT(a_take_no_done, clk, arst_n, take, !done, "result right after accept")
	`ISL_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result while still busy")
	`ISL_ASSERT_IMP(a_refused_zero, clk, arst_n, done && !ok, read_value == '0, "refused word carries data")
	`ISL_ASSERT_IMP(a_count_cap, clk, arst_n, done, int'(count) <= CAPACITY, "count above capacity")

endmodule

bind indexed_shift_list isl_checker #(.CAPACITY(CAPACITY)) u_isl_checker (.*);
